// ===== hw/rtl/pid_is_pkg.sv =====
`timescale 1ns / 1ps

package pid_is_pkg;

  localparam int unsigned MEAS_W   = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned THR_W    = 17;
  localparam int unsigned ILIM_W   = 23;
  localparam int unsigned OLIM_W   = 15;
  localparam int unsigned ERR_W    = 17;
  localparam int unsigned ISUM_W   = 24;
  localparam int unsigned DERIV_W  = 18;
  localparam int unsigned SHIFT_Q  = 8;
  localparam int unsigned TERMP_W  = GAIN_W + ERR_W - SHIFT_Q;
  localparam int unsigned TERMI_W  = GAIN_W + ISUM_W - SHIFT_Q;
  localparam int unsigned TERMD_W  = GAIN_W + DERIV_W - SHIFT_Q;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned CFG_W    = 23;

  localparam logic [THR_W-1:0]  THR_RST  = 17'd65536;
  localparam logic [ILIM_W-1:0] ILIM_RST = 23'd8388607;
  localparam logic [OLIM_W-1:0] OLIM_RST = 15'd32767;

  typedef enum logic [ADDR_W-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_SETPOINT = 3'd3,
    REG_SEP_THR  = 3'd4,
    REG_INT_LIM  = 3'd5,
    REG_OUT_LIM  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic signed [MEAS_W-1:0] setpoint;
    logic [THR_W-1:0]         sep_thr;
    logic [ILIM_W-1:0]        int_lim;
    logic [OLIM_W-1:0]        out_lim;
  } cfg_t;

  // error stage result
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [ISUM_W-1:0]  isum;
    logic signed [DERIV_W-1:0] deriv;
  } err_stage_t;

  // scaled gain terms
  typedef struct packed {
    logic signed [TERMP_W-1:0] term_p;
    logic signed [TERMI_W-1:0] term_i;
    logic signed [TERMD_W-1:0] term_d;
  } term_stage_t;

endpackage

// ===== hw/rtl/pid_integral_separation_top.sv =====
`timescale 1ns / 1ps
// PID controller with integral separation, four register stages deep.
// Throughput: one sample per cycle unless the output stalls; the integral state loop
// closes in the error stage.
// Stalls on the output hold the whole pipeline; bubbles are absorbed stage by stage.
// Reset (rst_n low, synchronous): pipeline emptied, integral and last error cleared,
// registers back to zero gains, zero setpoint and full-scale limits.

module pid_integral_separation_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pid_is_pkg::ADDR_W-1:0]   cfg_addr,
  input  logic [pid_is_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [15:0] measurement
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [15:0] drive
  output logic                            out_tuser   // [0] saturated
);

  pid_is_pkg::cfg_t        cfg_r;
  pid_is_pkg::err_stage_t  err_data;
  pid_is_pkg::term_stage_t term_data;
  logic                    err_valid;
  logic                    err_ready;
  logic                    term_valid;
  logic                    term_ready;
  logic signed [pid_is_pkg::MEAS_W-1:0] drive;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p   <= '0;
      cfg_r.gain_i   <= '0;
      cfg_r.gain_d   <= '0;
      cfg_r.setpoint <= '0;
      cfg_r.sep_thr  <= pid_is_pkg::THR_RST;
      cfg_r.int_lim  <= pid_is_pkg::ILIM_RST;
      cfg_r.out_lim  <= pid_is_pkg::OLIM_RST;
    end else if (cfg_we) begin
      unique case (pid_is_pkg::reg_idx_t'(cfg_addr))
        pid_is_pkg::REG_GAIN_P:   cfg_r.gain_p   <= cfg_wdata[pid_is_pkg::GAIN_W-1:0];
        pid_is_pkg::REG_GAIN_I:   cfg_r.gain_i   <= cfg_wdata[pid_is_pkg::GAIN_W-1:0];
        pid_is_pkg::REG_GAIN_D:   cfg_r.gain_d   <= cfg_wdata[pid_is_pkg::GAIN_W-1:0];
        pid_is_pkg::REG_SETPOINT: cfg_r.setpoint <= cfg_wdata[pid_is_pkg::MEAS_W-1:0];
        pid_is_pkg::REG_SEP_THR:  cfg_r.sep_thr  <= cfg_wdata[pid_is_pkg::THR_W-1:0];
        pid_is_pkg::REG_INT_LIM:  cfg_r.int_lim  <= cfg_wdata[pid_is_pkg::ILIM_W-1:0];
        pid_is_pkg::REG_OUT_LIM:  cfg_r.out_lim  <= cfg_wdata[pid_is_pkg::OLIM_W-1:0];
        default: ; // ignore writes beyond the register list
      endcase
    end
  end

  pid_is_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_meas   ($signed(in_tdata)),
    .out_valid (err_valid),
    .out_ready (err_ready),
    .out_data  (err_data)
  );

  pid_is_terms u_terms (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_data   (err_data),
    .out_valid (term_valid),
    .out_ready (term_ready),
    .out_data  (term_data)
  );

  pid_is_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_lim   (cfg_r.out_lim),
    .in_valid  (term_valid),
    .in_ready  (term_ready),
    .in_data   (term_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_drive (drive),
    .out_sat   (out_tuser)
  );

  assign out_tdata = drive;

endmodule

// ===== hw/rtl/pid_is_front.sv =====
`timescale 1ns / 1ps

module pid_is_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  pid_is_pkg::cfg_t                      cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pid_is_pkg::MEAS_W-1:0]  in_meas,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output pid_is_pkg::err_stage_t                out_data
);

  localparam int unsigned SUM_W = pid_is_pkg::ISUM_W + 1;

  logic                                 meas_vld_r;
  logic signed [pid_is_pkg::MEAS_W-1:0] meas_r;
  logic                                 err_vld_r;
  pid_is_pkg::err_stage_t               err_r;
  pid_is_pkg::err_stage_t               err_nxt;
  logic signed [pid_is_pkg::ISUM_W-1:0]  error_sum_r;
  logic signed [pid_is_pkg::ERR_W-1:0]   last_error_r;

  logic                                 stage2_rdy;
  logic                                 stage1_rdy;
  logic signed [pid_is_pkg::ERR_W-1:0]  err;
  logic [pid_is_pkg::ERR_W-1:0]         mag;
  logic signed [SUM_W-1:0]              acc;
  logic signed [SUM_W-1:0]              lim;
  logic signed [pid_is_pkg::ISUM_W-1:0] isum_clamped;

  assign stage2_rdy = !err_vld_r || out_ready;
  assign stage1_rdy = !meas_vld_r || stage2_rdy;
  assign in_ready   = stage1_rdy;

  always_comb begin
    err = $signed({cfg.setpoint[pid_is_pkg::MEAS_W-1], cfg.setpoint})
        - $signed({meas_r[pid_is_pkg::MEAS_W-1], meas_r});
    mag = err[pid_is_pkg::ERR_W-1] ? pid_is_pkg::ERR_W'(-err) : err;
    acc = $signed({error_sum_r[pid_is_pkg::ISUM_W-1], error_sum_r})
        + SUM_W'(err);
    lim = $signed({{(SUM_W - pid_is_pkg::ILIM_W){1'b0}}, cfg.int_lim});
    priority if (acc > lim) begin
      isum_clamped = pid_is_pkg::ISUM_W'(lim);
    end else if (acc < -lim) begin
      isum_clamped = pid_is_pkg::ISUM_W'(-lim);
    end else begin
      isum_clamped = acc[pid_is_pkg::ISUM_W-1:0];
    end
    err_nxt.err   = err;
    // integrate only inside the separation band, otherwise drop the integral
    err_nxt.isum  = (mag < cfg.sep_thr) ? isum_clamped : '0;
    err_nxt.deriv = pid_is_pkg::DERIV_W'(err) - pid_is_pkg::DERIV_W'(last_error_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_vld_r   <= 1'b0;
      err_vld_r    <= 1'b0;
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else begin
      if (stage1_rdy) begin
        meas_vld_r <= in_valid;
      end
      if (stage2_rdy) begin
        err_vld_r <= meas_vld_r;
        if (meas_vld_r) begin
          error_sum_r  <= err_nxt.isum;
          last_error_r <= err_nxt.err;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage1_rdy && in_valid) begin
      meas_r <= in_meas;
    end
    if (stage2_rdy && meas_vld_r) begin
      err_r <= err_nxt;
    end
  end

  assign out_valid = err_vld_r;
  assign out_data  = err_r;

endmodule

// ===== hw/rtl/pid_is_terms.sv =====
`timescale 1ns / 1ps

module pid_is_terms (
  input  logic                    clk,
  input  logic                    rst_n,
  input  pid_is_pkg::cfg_t        cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pid_is_pkg::err_stage_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output pid_is_pkg::term_stage_t out_data
);

  localparam int unsigned PP_W = pid_is_pkg::GAIN_W + pid_is_pkg::ERR_W;
  localparam int unsigned PI_W = pid_is_pkg::GAIN_W + pid_is_pkg::ISUM_W;
  localparam int unsigned PD_W = pid_is_pkg::GAIN_W + pid_is_pkg::DERIV_W;

  logic                    term_vld_r;
  pid_is_pkg::term_stage_t term_r;
  pid_is_pkg::term_stage_t term_nxt;
  logic signed [PP_W-1:0]  prod_p;
  logic signed [PI_W-1:0]  prod_i;
  logic signed [PD_W-1:0]  prod_d;

  assign in_ready = !term_vld_r || out_ready;

  always_comb begin
    prod_p = $signed(cfg.gain_p) * $signed(in_data.err);
    prod_i = $signed(cfg.gain_i) * $signed(in_data.isum);
    prod_d = $signed(cfg.gain_d) * $signed(in_data.deriv);
    // dropping the low fraction bits rounds toward minus infinity
    term_nxt.term_p = prod_p[PP_W-1:pid_is_pkg::SHIFT_Q];
    term_nxt.term_i = prod_i[PI_W-1:pid_is_pkg::SHIFT_Q];
    term_nxt.term_d = prod_d[PD_W-1:pid_is_pkg::SHIFT_Q];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_vld_r <= 1'b0;
    end else if (in_ready) begin
      term_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      term_r <= term_nxt;
    end
  end

  assign out_valid = term_vld_r;
  assign out_data  = term_r;

endmodule

// ===== hw/rtl/pid_is_out.sv =====
`timescale 1ns / 1ps

module pid_is_out (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [pid_is_pkg::OLIM_W-1:0]         out_lim,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  pid_is_pkg::term_stage_t               in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pid_is_pkg::MEAS_W-1:0]  out_drive,
  output logic                                  out_sat
);

  localparam int unsigned TOT_W = pid_is_pkg::TERMI_W + 2;

  logic                                 res_vld_r;
  logic signed [pid_is_pkg::MEAS_W-1:0] drive_r;
  logic signed [pid_is_pkg::MEAS_W-1:0] drive_nxt;
  logic                                 sat_r;
  logic                                 sat_nxt;
  logic signed [TOT_W-1:0]              total;
  logic signed [TOT_W-1:0]              lim;

  assign in_ready = !res_vld_r || out_ready;

  always_comb begin
    total = TOT_W'(in_data.term_p) + TOT_W'(in_data.term_i) + TOT_W'(in_data.term_d);
    lim   = $signed({{(TOT_W - pid_is_pkg::OLIM_W){1'b0}}, out_lim});
    priority if (total > lim) begin
      drive_nxt = pid_is_pkg::MEAS_W'(lim);
      sat_nxt   = 1'b1;
    end else if (total < -lim) begin
      drive_nxt = pid_is_pkg::MEAS_W'(-lim);
      sat_nxt   = 1'b1;
    end else begin
      drive_nxt = total[pid_is_pkg::MEAS_W-1:0];
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (in_ready) begin
      res_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      drive_r <= drive_nxt;
      sat_r   <= sat_nxt;
    end
  end

  assign out_valid = res_vld_r;
  assign out_drive = drive_r;
  assign out_sat   = sat_r;

endmodule

// ===== bench/pid_integral_separation_top_tb.sv =====
`timescale 1ns / 1ps

module pid_integral_separation_top_tb;

  // address past the end of the register map; writes to it must be ignored
  localparam logic [pid_is_pkg::ADDR_W-1:0] REG_UNUSED = 3'd7;

  localparam logic [pid_is_pkg::CFG_W-1:0] CFG_S16_MAX  = 23'sd32767;
  localparam logic [pid_is_pkg::CFG_W-1:0] CFG_S16_MIN  = -23'sd32768;
  localparam logic [pid_is_pkg::CFG_W-1:0] CFG_THR_RST  =
    pid_is_pkg::CFG_W'(pid_is_pkg::THR_RST);
  localparam logic [pid_is_pkg::CFG_W-1:0] CFG_ILIM_RST =
    pid_is_pkg::CFG_W'(pid_is_pkg::ILIM_RST);
  localparam logic [pid_is_pkg::CFG_W-1:0] CFG_OLIM_RST =
    pid_is_pkg::CFG_W'(pid_is_pkg::OLIM_RST);

  typedef struct packed {
    logic [15:0] drive;
    logic        saturated;
  } pid_out_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [pid_is_pkg::ADDR_W-1:0] cfg_addr;
  logic [pid_is_pkg::CFG_W-1:0]  cfg_wdata;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [15:0]                   in_tdata;   // [15:0] measurement
  logic                          out_tvalid;
  logic                          out_tready;
  logic [15:0]                   out_tdata;  // [15:0] drive
  logic                          out_tuser;  // [0] saturated

  // controller copy: registers and loop state
  pid_is_pkg::cfg_t                     ctl_regs;
  logic signed [pid_is_pkg::ISUM_W-1:0] isum_acc;
  logic signed [pid_is_pkg::ERR_W-1:0]  last_err_q;

  pid_out_t expected_drive_q[$];
  int       mismatch_count = 0;
  int       burst_left;

  pid_integral_separation_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // One control step: error, separated integral, derivative, scaled terms, output clamp.
  function automatic pid_out_t next_drive(input logic signed [pid_is_pkg::MEAS_W-1:0] meas);
    longint   err;
    longint   mag;
    longint   acc;
    longint   deriv;
    longint   sum;
    longint   lim;
    pid_out_t res;
    err = longint'($signed(ctl_regs.setpoint)) - longint'(meas);
    mag = (err < 0) ? -err : err;
    if (mag < longint'(ctl_regs.sep_thr)) begin
      lim = longint'(ctl_regs.int_lim);
      acc = longint'(isum_acc) + err;
      if (acc > lim) acc = lim;
      else if (acc < -lim) acc = -lim;
    end else begin
      acc = 0;
    end
    isum_acc = acc[pid_is_pkg::ISUM_W-1:0];
    deriv = err - longint'(last_err_q);
    last_err_q = err[pid_is_pkg::ERR_W-1:0];
    // arithmetic shift of a signed product rounds toward minus infinity
    sum = ((longint'($signed(ctl_regs.gain_p)) * err) >>> pid_is_pkg::SHIFT_Q)
        + ((longint'($signed(ctl_regs.gain_i)) * acc) >>> pid_is_pkg::SHIFT_Q)
        + ((longint'($signed(ctl_regs.gain_d)) * deriv) >>> pid_is_pkg::SHIFT_Q);
    lim = longint'(ctl_regs.out_lim);
    res.saturated = 1'b1;
    if (sum > lim) sum = lim;
    else if (sum < -lim) sum = -lim;
    else res.saturated = 1'b0;
    res.drive = sum[15:0];
    return res;
  endfunction

  // Compare every output transaction with the oldest prediction.
  always @(posedge clk) begin
    pid_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_drive_q.size() == 0) begin
        $display("%0t: unexpected result, actual drive %0d saturated %0b", $time,
                 $signed(out_tdata), out_tuser);
        mismatch_count++;
      end else begin
        want = expected_drive_q.pop_front();
        if (out_tdata !== want.drive) begin
          $display("%0t: drive mismatch, expected %0d, actual %0d", $time,
                   $signed(want.drive), $signed(out_tdata));
          mismatch_count++;
        end
        if (out_tuser !== want.saturated) begin
          $display("%0t: saturated mismatch, expected %0b, actual %0b", $time,
                   want.saturated, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Receiver: stretches of a repeating ready pattern, some of them never stalling.
  initial begin : stall_pattern
    logic [15:0] mask;
    int          stretch;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 3) == 0) mask = 16'hffff;
      else mask = 16'($urandom) | 16'h0001;
      stretch = $urandom_range(16, 96);
      for (int k = 0; k < stretch; k++) begin
        @(negedge clk);
        out_tready <= mask[k % 16];
      end
    end
  end

  task automatic hold_off_sender(input int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Present one measurement, predict at acceptance, then pace the next burst.
  task automatic send_sample(input logic [15:0] meas);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= meas;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_drive_q.push_back(next_drive(meas));
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) hold_off_sender($urandom_range(1, 6));
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Drop valid and hold until every predicted result has been seen.
  task automatic wait_for_results();
    hold_off_sender(1);
    while (expected_drive_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pid_is_pkg::ADDR_W-1:0] addr,
                           input logic [pid_is_pkg::CFG_W-1:0]  data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      pid_is_pkg::REG_GAIN_P:   ctl_regs.gain_p   = data[pid_is_pkg::GAIN_W-1:0];
      pid_is_pkg::REG_GAIN_I:   ctl_regs.gain_i   = data[pid_is_pkg::GAIN_W-1:0];
      pid_is_pkg::REG_GAIN_D:   ctl_regs.gain_d   = data[pid_is_pkg::GAIN_W-1:0];
      pid_is_pkg::REG_SETPOINT: ctl_regs.setpoint = data[pid_is_pkg::MEAS_W-1:0];
      pid_is_pkg::REG_SEP_THR:  ctl_regs.sep_thr  = data[pid_is_pkg::THR_W-1:0];
      pid_is_pkg::REG_INT_LIM:  ctl_regs.int_lim  = data[pid_is_pkg::ILIM_W-1:0];
      pid_is_pkg::REG_OUT_LIM:  ctl_regs.out_lim  = data[pid_is_pkg::OLIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_controller(input logic [pid_is_pkg::CFG_W-1:0] gp,
                                    input logic [pid_is_pkg::CFG_W-1:0] gi,
                                    input logic [pid_is_pkg::CFG_W-1:0] gd,
                                    input logic [pid_is_pkg::CFG_W-1:0] sp,
                                    input logic [pid_is_pkg::CFG_W-1:0] thr,
                                    input logic [pid_is_pkg::CFG_W-1:0] ilim,
                                    input logic [pid_is_pkg::CFG_W-1:0] olim);
    write_reg(pid_is_pkg::REG_GAIN_P, gp);
    write_reg(pid_is_pkg::REG_GAIN_I, gi);
    write_reg(pid_is_pkg::REG_GAIN_D, gd);
    write_reg(pid_is_pkg::REG_SETPOINT, sp);
    write_reg(pid_is_pkg::REG_SEP_THR, thr);
    write_reg(pid_is_pkg::REG_INT_LIM, ilim);
    write_reg(pid_is_pkg::REG_OUT_LIM, olim);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // upper data bits beyond each register are left random; the block must drop them
  function automatic logic [pid_is_pkg::CFG_W-1:0] pick_gain();
    logic [pid_is_pkg::CFG_W-1:0] g;
    g = pid_is_pkg::CFG_W'($urandom);
    if ($urandom_range(0, 2) != 0) g[15:0] = 16'($urandom_range(0, 1024) - 512);
    return g;
  endfunction

  function automatic logic [pid_is_pkg::CFG_W-1:0] pick_thr();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CFG_THR_RST;
      2:       return pid_is_pkg::CFG_W'($urandom_range(0, 65536));
      3:       return pid_is_pkg::CFG_W'($urandom_range(1, 8192));
      default: return pid_is_pkg::CFG_W'($urandom);
    endcase
  endfunction

  function automatic logic [pid_is_pkg::CFG_W-1:0] pick_ilim();
    case ($urandom_range(0, 4))
      0:       return CFG_ILIM_RST;
      1:       return '0;
      2:       return pid_is_pkg::CFG_W'($urandom_range(0, 2000));
      default: return pid_is_pkg::CFG_W'($urandom);
    endcase
  endfunction

  function automatic logic [pid_is_pkg::CFG_W-1:0] pick_olim();
    logic [pid_is_pkg::CFG_W-1:0] o;
    o = pid_is_pkg::CFG_W'($urandom);
    case ($urandom_range(0, 4))
      0:       o[pid_is_pkg::OLIM_W-1:0] = pid_is_pkg::OLIM_RST;
      1:       o[pid_is_pkg::OLIM_W-1:0] = '0;
      2:       o[pid_is_pkg::OLIM_W-1:0] = pid_is_pkg::OLIM_W'($urandom_range(0, 4000));
      default: ;
    endcase
    return o;
  endfunction

  task automatic test_reset_defaults();
    // zero gains, full-scale limits: every error integrated, drive stays zero
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h0000);
    wait_for_results();
  endtask

  task automatic test_extreme_values();
    program_controller(CFG_S16_MAX, CFG_S16_MAX, CFG_S16_MAX, CFG_S16_MAX,
                       CFG_THR_RST, CFG_ILIM_RST, CFG_OLIM_RST);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    wait_for_results();
    // tight integral clamp against the largest negative error
    program_controller(CFG_S16_MIN, CFG_S16_MIN, CFG_S16_MIN, CFG_S16_MIN,
                       CFG_THR_RST, 23'd1000, CFG_OLIM_RST);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    wait_for_results();
  endtask

  task automatic test_separation_threshold();
    // zero threshold clears the integral on every sample
    program_controller(23'd256, 23'd256, 23'd256, '0, '0, CFG_ILIM_RST, CFG_OLIM_RST);
    send_sample(16'h0000);
    send_sample(16'd5);
    send_sample(-16'sd5);
    wait_for_results();
    // error equal to the threshold clears, one below integrates
    program_controller(23'd256, 23'd256, '0, '0, 23'd100, CFG_ILIM_RST, CFG_OLIM_RST);
    send_sample(-16'sd100);
    send_sample(-16'sd99);
    wait_for_results();
  endtask

  task automatic test_zero_limits();
    program_controller(23'd256, 23'd256, 23'd256, '0, CFG_THR_RST, '0, '0);
    send_sample(16'h0000);
    send_sample(16'd10);
    send_sample(-16'sd10);
    wait_for_results();
  endtask

  task automatic test_exact_limit();
    // unity proportional gain: sum equals the error
    program_controller(23'd256, '0, '0, '0, CFG_THR_RST, CFG_ILIM_RST, 23'd100);
    send_sample(-16'sd100);
    send_sample(-16'sd101);
    send_sample(16'd100);
    send_sample(16'd101);
    wait_for_results();
  endtask

  task automatic test_unmapped_index();
    write_reg(REG_UNUSED, '1);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_sample(16'd7);
    send_sample(-16'sd7);
    wait_for_results();
  endtask

  task automatic test_random_phases();
    int          spread;
    int          offset;
    logic [15:0] meas;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0)
        program_controller(CFG_S16_MAX, CFG_S16_MAX, CFG_S16_MAX, CFG_S16_MAX,
                           CFG_THR_RST, CFG_ILIM_RST, CFG_OLIM_RST);
      else if (ph == 1)
        program_controller(CFG_S16_MIN, CFG_S16_MIN, CFG_S16_MIN, CFG_S16_MIN,
                           '0, '0, CFG_OLIM_RST);
      else
        program_controller(pick_gain(), pick_gain(), pick_gain(),
                           pid_is_pkg::CFG_W'($urandom),
                           pick_thr(), pick_ilim(), pick_olim());
      case ($urandom_range(0, 2))
        0:       spread = 16;
        1:       spread = 256;
        default: spread = 4096;
      endcase
      for (int n = 0; n < 210; n++) begin
        // mostly hover around the setpoint so the integral path stays busy
        if ($urandom_range(0, 4) == 0) begin
          meas = 16'($urandom);
        end else begin
          offset = $urandom_range(0, 2 * spread) - spread;
          meas = 16'(int'($signed(ctl_regs.setpoint)) + offset);
        end
        send_sample(meas);
        if (n == 105) wait_for_results();
      end
      wait_for_results();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = pid_is_pkg::REG_GAIN_P;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    burst_left     = $urandom_range(1, 24);
    ctl_regs.gain_p   = '0;
    ctl_regs.gain_i   = '0;
    ctl_regs.gain_d   = '0;
    ctl_regs.setpoint = '0;
    ctl_regs.sep_thr  = pid_is_pkg::THR_RST;
    ctl_regs.int_lim  = pid_is_pkg::ILIM_RST;
    ctl_regs.out_lim  = pid_is_pkg::OLIM_RST;
    isum_acc   = '0;
    last_err_q = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_extreme_values();
    test_separation_threshold();
    test_zero_limits();
    test_exact_limit();
    test_unmapped_index();
    test_random_phases();

    wait_for_results();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pid_is_pkg.sv
hw/rtl/pid_is_front.sv
hw/rtl/pid_is_terms.sv
hw/rtl/pid_is_out.sv
hw/rtl/pid_integral_separation_top.sv
bench/pid_integral_separation_top_tb.sv
